@@ rtl/lcdtr_pkg.sv @@
// shared constants, beat codes and the 5x7 glyph table for the lcd text renderer
package lcdtr_pkg;

    localparam int ColumnsDefault = 84;
    localparam int BanksDefault   = 6;

    localparam int GlyphCount = 96;
    localparam int GlyphIdxW  = 7;
    localparam int GlyphW     = 40;
    localparam int BeatW      = 4;

    localparam logic [7:0] CodeNewline = 8'h0A;
    localparam logic [7:0] CodeReturn  = 8'h0D;
    localparam logic [7:0] GlyphFirst  = 8'h20;
    localparam logic [7:0] CmdColumn   = 8'h80;
    localparam logic [7:0] CmdBank     = 8'h40;
    localparam logic [7:0] ByteBlank   = 8'h00;
    localparam logic [6:0] ColumnStep  = 7'd6;

    // beat numbering of one item's output run
    localparam logic [BeatW-1:0] BeatLead      = 4'd0;
    localparam logic [BeatW-1:0] BeatCol0      = 4'd1;
    localparam logic [BeatW-1:0] BeatCol1      = 4'd2;
    localparam logic [BeatW-1:0] BeatCol2      = 4'd3;
    localparam logic [BeatW-1:0] BeatCol3      = 4'd4;
    localparam logic [BeatW-1:0] BeatCol4      = 4'd5;
    localparam logic [BeatW-1:0] BeatTrail     = 4'd6;
    localparam logic [BeatW-1:0] BeatCmdColumn = 4'd7;
    localparam logic [BeatW-1:0] BeatCmdBank   = 4'd8;

    typedef logic [GlyphW-1:0] t_glyph;

    // first column sits in the top byte
    function automatic t_glyph glyph_bits(input logic [GlyphIdxW-1:0] idx);
        t_glyph g;
        case (idx)
            7'd0:  g = 40'h00_00_00_00_00;
            7'd1:  g = 40'h00_00_5f_00_00;
            7'd2:  g = 40'h00_07_00_07_00;
            7'd3:  g = 40'h14_7f_14_7f_14;
            7'd4:  g = 40'h24_2a_7f_2a_12;
            7'd5:  g = 40'h23_13_08_64_62;
            7'd6:  g = 40'h36_49_55_22_50;
            7'd7:  g = 40'h00_05_03_00_00;
            7'd8:  g = 40'h00_1c_22_41_00;
            7'd9:  g = 40'h00_41_22_1c_00;
            7'd10: g = 40'h14_08_3e_08_14;
            7'd11: g = 40'h08_08_3e_08_08;
            7'd12: g = 40'h00_50_30_00_00;
            7'd13: g = 40'h08_08_08_08_08;
            7'd14: g = 40'h00_60_60_00_00;
            7'd15: g = 40'h20_10_08_04_02;
            7'd16: g = 40'h3e_51_49_45_3e;
            7'd17: g = 40'h00_42_7f_40_00;
            7'd18: g = 40'h42_61_51_49_46;
            7'd19: g = 40'h21_41_45_4b_31;
            7'd20: g = 40'h18_14_12_7f_10;
            7'd21: g = 40'h27_45_45_45_39;
            7'd22: g = 40'h3c_4a_49_49_30;
            7'd23: g = 40'h01_71_09_05_03;
            7'd24: g = 40'h36_49_49_49_36;
            7'd25: g = 40'h06_49_49_29_1e;
            7'd26: g = 40'h00_36_36_00_00;
            7'd27: g = 40'h00_56_36_00_00;
            7'd28: g = 40'h08_14_22_41_00;
            7'd29: g = 40'h14_14_14_14_14;
            7'd30: g = 40'h00_41_22_14_08;
            7'd31: g = 40'h02_01_51_09_06;
            7'd32: g = 40'h32_49_79_41_3e;
            7'd33: g = 40'h7e_11_11_11_7e;
            7'd34: g = 40'h7f_49_49_49_36;
            7'd35: g = 40'h3e_41_41_41_22;
            7'd36: g = 40'h7f_41_41_22_1c;
            7'd37: g = 40'h7f_49_49_49_41;
            7'd38: g = 40'h7f_09_09_09_01;
            7'd39: g = 40'h3e_41_49_49_7a;
            7'd40: g = 40'h7f_08_08_08_7f;
            7'd41: g = 40'h00_41_7f_41_00;
            7'd42: g = 40'h20_40_41_3f_01;
            7'd43: g = 40'h7f_08_14_22_41;
            7'd44: g = 40'h7f_40_40_40_40;
            7'd45: g = 40'h7f_02_0c_02_7f;
            7'd46: g = 40'h7f_04_08_10_7f;
            7'd47: g = 40'h3e_41_41_41_3e;
            7'd48: g = 40'h7f_09_09_09_06;
            7'd49: g = 40'h3e_41_51_21_5e;
            7'd50: g = 40'h7f_09_19_29_46;
            7'd51: g = 40'h46_49_49_49_31;
            7'd52: g = 40'h01_01_7f_01_01;
            7'd53: g = 40'h3f_40_40_40_3f;
            7'd54: g = 40'h1f_20_40_20_1f;
            7'd55: g = 40'h3f_40_38_40_3f;
            7'd56: g = 40'h63_14_08_14_63;
            7'd57: g = 40'h07_08_70_08_07;
            7'd58: g = 40'h61_51_49_45_43;
            7'd59: g = 40'h00_7f_41_41_00;
            7'd60: g = 40'h02_04_08_10_20;
            7'd61: g = 40'h00_41_41_7f_00;
            7'd62: g = 40'h04_02_01_02_04;
            7'd63: g = 40'h40_40_40_40_40;
            7'd64: g = 40'h00_01_02_04_00;
            7'd65: g = 40'h20_54_54_54_78;
            7'd66: g = 40'h7f_48_44_44_38;
            7'd67: g = 40'h38_44_44_44_20;
            7'd68: g = 40'h38_44_44_48_7f;
            7'd69: g = 40'h38_54_54_54_18;
            7'd70: g = 40'h08_7e_09_01_02;
            7'd71: g = 40'h0c_52_52_52_3e;
            7'd72: g = 40'h7f_08_04_04_78;
            7'd73: g = 40'h00_44_7d_40_00;
            7'd74: g = 40'h20_40_44_3d_00;
            7'd75: g = 40'h7f_10_28_44_00;
            7'd76: g = 40'h00_41_7f_40_00;
            7'd77: g = 40'h7c_04_18_04_78;
            7'd78: g = 40'h7c_08_04_04_78;
            7'd79: g = 40'h38_44_44_44_38;
            7'd80: g = 40'h7c_14_14_14_08;
            7'd81: g = 40'h08_14_14_18_7c;
            7'd82: g = 40'h7c_08_04_04_08;
            7'd83: g = 40'h48_54_54_54_20;
            7'd84: g = 40'h04_3f_44_40_20;
            7'd85: g = 40'h3c_40_40_20_7c;
            7'd86: g = 40'h1c_20_40_20_1c;
            7'd87: g = 40'h3c_40_30_40_3c;
            7'd88: g = 40'h44_28_10_28_44;
            7'd89: g = 40'h0c_50_50_50_3c;
            7'd90: g = 40'h44_64_54_4c_44;
            7'd91: g = 40'h00_08_36_41_00;
            7'd92: g = 40'h00_00_7f_00_00;
            7'd93: g = 40'h00_41_36_08_00;
            7'd94: g = 40'h10_08_08_10_08;
            7'd95: g = 40'h00_06_09_09_06;
            default: g = '0;
        endcase
        return g;
    endfunction

endpackage

@@ rtl/lcd_text_column_renderer_unit.sv @@
// top level of the lcd text renderer: item intake, beat sequencer and output register
// Each character item turns into a run of bytes for the display controller, one byte
// per cycle unless i_stall holds the output, from a single output register: a glyph
// (any code but newline and carriage return) gives 7 data bytes, 9 when the cursor
// wraps and the two position commands follow; a newline gives the 2 commands; a
// carriage return gives none and is only taken in. The beat counter steps through
// the bytes of an item, and the next item is taken in the cycle its last byte is
// loaded, keeping the output busy without gaps. The glyph columns come from a font rom
// read once when the item is taken; its word is ready for the first glyph column.
module lcd_text_column_renderer_unit
    import lcdtr_pkg::*;
#(
    parameter int COLUMNS = ColumnsDefault,
    parameter int BANKS   = BanksDefault
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_char_code,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_lcd_byte,
    output logic       o_is_data,
    output logic       o_last
);

    logic             r_busy;
    logic [BeatW-1:0] r_beat;
    logic [BeatW-1:0] r_last_beat;
    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic             r_out_data;
    logic             r_out_last;

    logic             advance;
    logic             finish;
    logic             accept;
    logic             is_newline;
    logic             is_return;
    logic             wrap;
    logic [2:0]       bank;
    t_glyph           glyph;
    logic [7:0]       beat_byte;

    assign advance    = r_busy && (!r_out_valid || !i_stall);
    assign finish     = advance && (r_beat == r_last_beat);
    assign o_stall    = r_busy && !finish;
    assign accept     = i_valid && !o_stall;
    assign is_newline = (i_char_code == CodeNewline);
    assign is_return  = (i_char_code == CodeReturn);

    lcdtr_font_rom u_font_rom (
        .i_clk   (i_clk),
        .i_rd_en (accept),
        .i_code  (i_char_code),
        .o_glyph (glyph)
    );

    lcdtr_cursor #(
        .COLUMNS (COLUMNS),
        .BANKS   (BANKS)
    ) u_cursor (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_glyph_step (accept && !is_newline && !is_return),
        .i_newline    (accept && is_newline),
        .o_wrap       (wrap),
        .o_bank       (bank)
    );

    always_comb begin
        unique case (r_beat)
            BeatCol0:      beat_byte = glyph[39:32];
            BeatCol1:      beat_byte = glyph[31:24];
            BeatCol2:      beat_byte = glyph[23:16];
            BeatCol3:      beat_byte = glyph[15:8];
            BeatCol4:      beat_byte = glyph[7:0];
            BeatCmdColumn: beat_byte = CmdColumn;
            BeatCmdBank:   beat_byte = CmdBank | {5'b0, bank};
            default:       beat_byte = ByteBlank;
        endcase
    end

    // sequencer: a newline starts at the command beats, a glyph at the lead blank
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_beat      <= BeatLead;
            r_last_beat <= BeatTrail;
        end else if (accept && !is_return) begin
            r_busy <= 1'b1;
            if (is_newline) begin
                r_beat      <= BeatCmdColumn;
                r_last_beat <= BeatCmdBank;
            end else begin
                r_beat      <= BeatLead;
                r_last_beat <= wrap ? BeatCmdBank : BeatTrail;
            end
        end else if (finish) begin
            r_busy <= 1'b0;
        end else if (advance) begin
            r_beat <= r_beat + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_byte <= beat_byte;
            r_out_data <= (r_beat < BeatCmdColumn);
            r_out_last <= (r_beat == r_last_beat);
        end
    end

    assign o_valid    = r_out_valid;
    assign o_lcd_byte = r_out_byte;
    assign o_is_data  = r_out_data;
    assign o_last     = r_out_last;

endmodule

@@ rtl/lcdtr_font_rom.sv @@
// synchronous 5x7 font rom, one glyph word per read, registered output
module lcdtr_font_rom
    import lcdtr_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rd_en,
    input  logic [7:0]   i_code,
    output t_glyph       o_glyph
);

    logic                 printable;
    logic [GlyphIdxW-1:0] idx;
    t_glyph               r_glyph;

    // anything outside the printable range reads the space glyph, which is blank
    assign printable = (i_code[7] == 1'b0) && (i_code[6:5] != 2'b00);
    assign idx       = printable ? (i_code[6:0] - GlyphFirst[6:0]) : '0;

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_glyph <= glyph_bits(idx);
        end
    end

    assign o_glyph = r_glyph;

endmodule

@@ rtl/lcdtr_cursor.sv @@
// cursor column and bank registers with the line wrap logic
module lcdtr_cursor
    import lcdtr_pkg::*;
#(
    parameter int COLUMNS = ColumnsDefault,
    parameter int BANKS   = BanksDefault
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_glyph_step,
    input  logic       i_newline,
    output logic       o_wrap,
    output logic [2:0] o_bank
);

    localparam logic [6:0] WrapColumn = 7'(COLUMNS - 6);
    localparam logic [3:0] BankCount  = 4'(BANKS);

    logic [6:0] r_column, n_column;
    logic [2:0] r_bank, n_bank;
    logic [6:0] col_step;
    logic [2:0] bank_inc;
    logic [2:0] bank_adv;

    assign col_step = r_column + ColumnStep;
    assign o_wrap   = (col_step >= WrapColumn);
    assign bank_inc = r_bank + 3'd1;
    assign bank_adv = ({1'b0, bank_inc} >= BankCount) ? 3'd0 : bank_inc;

    always_comb begin
        n_column = r_column;
        n_bank   = r_bank;
        if (i_newline) begin
            n_column = '0;
            n_bank   = bank_adv;
        end else if (i_glyph_step) begin
            if (o_wrap) begin
                n_column = '0;
                n_bank   = bank_adv;
            end else begin
                n_column = col_step;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column <= '0;
            r_bank   <= '0;
        end else begin
            r_column <= n_column;
            r_bank   <= n_bank;
        end
    end

    assign o_bank = r_bank;

endmodule
